// ===== src/lfc_pkg.sv =====
// Package for the three-sensor line-follow controller.
// Holds payload and configuration types, code enums and constants.
// No dependencies.
`default_nettype none
package lfc_pkg;

	localparam int PWM_MAX_DEF   = 255;
	localparam int TIME_BITS_DEF = 32;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEFT_THRESHOLD  = 3'd0,
		REG_RIGHT_THRESHOLD = 3'd1,
		REG_BASE_SPEED      = 3'd2,
		REG_TURN_SPEED      = 3'd3,
		REG_CURVE_ADJUST    = 3'd4,
		REG_LINE_LOST_MS    = 3'd5,
		REG_DEAD_CONFIRM_MS = 3'd6,
		REG_CROSS_PASS_MS   = 3'd7
	} reg_idx_t;

	typedef enum logic [3:0] {
		ACT_FWD        = 4'd0,
		ACT_CURVE_R    = 4'd1,
		ACT_CURVE_L    = 4'd2,
		ACT_SHARP_R    = 4'd3,
		ACT_SHARP_L    = 4'd4,
		ACT_CHECK_DEAD = 4'd5,
		ACT_BACKUP     = 4'd6,
		ACT_SPIN180    = 4'd7,
		ACT_CROSS      = 4'd8,
		ACT_BRIDGE     = 4'd9,
		ACT_REC_R      = 4'd10,
		ACT_REC_L      = 4'd11,
		ACT_KEEP       = 4'd12
	} action_t;

	typedef enum logic [1:0] {
		DIR_STOP = 2'd0,
		DIR_FWD  = 2'd1,
		DIR_REV  = 2'd2
	} dir_t;

	typedef enum logic [2:0] {
		HEAD_CENTRE = 3'b001,
		HEAD_MINUS  = 3'b010,
		HEAD_PLUS   = 3'b100
	} heading_t;

	// Fixed PWM values and offsets of the command table.
	localparam logic signed [10:0] DEAD_OFS   = 11'sd50;
	localparam logic signed [10:0] TURN_OFS   = 11'sd40;
	localparam logic signed [10:0] BACKUP_PWM = 11'sd150;
	localparam logic signed [10:0] SPIN_PWM   = 11'sd180;
	localparam logic signed [10:0] REC_PWM    = 11'sd150;

	localparam logic [9:0] HOLD_NORMAL = 10'd10;
	localparam logic [9:0] HOLD_BACKUP = 10'd300;
	localparam logic [9:0] HOLD_SPIN   = 10'd900;

	typedef struct packed {
		logic [9:0]  left_level;
		logic        middle_on;
		logic [9:0]  right_level;
		logic [31:0] now_ms;
	} in_t;

	typedef struct packed {
		action_t    action;
		dir_t       left_dir;
		dir_t       right_dir;
		logic [7:0] left_pwm;
		logic [7:0] right_pwm;
		logic [9:0] hold_ms;
		logic       last_of_run;
	} out_t;

	typedef struct packed {
		logic [9:0]  left_threshold;
		logic [9:0]  right_threshold;
		logic [7:0]  base_speed;
		logic [7:0]  turn_speed;
		logic [7:0]  curve_adjust;
		logic [15:0] line_lost_timeout_ms;
		logic [15:0] dead_end_confirm_ms;
		logic [15:0] intersection_pass_ms;
	} cfg_t;

endpackage
`default_nettype wire

// ===== src/lfc_cfg.sv =====
// Configuration register file of the line-follow controller.
// Depends on lfc_pkg.
`default_nettype none
module lfc_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [lfc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [lfc_pkg::CFG_DATA_W-1:0] cfg_data,
	output lfc_pkg::cfg_t                      cfg
);
	import lfc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left_threshold       <= 10'd300;
			cfg_q.right_threshold      <= 10'd300;
			cfg_q.base_speed           <= 8'd180;
			cfg_q.turn_speed           <= 8'd140;
			cfg_q.curve_adjust         <= 8'd40;
			cfg_q.line_lost_timeout_ms <= 16'd600;
			cfg_q.dead_end_confirm_ms  <= 16'd150;
			cfg_q.intersection_pass_ms <= 16'd300;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_LEFT_THRESHOLD:  cfg_q.left_threshold       <= cfg_data[9:0];
				REG_RIGHT_THRESHOLD: cfg_q.right_threshold      <= cfg_data[9:0];
				REG_BASE_SPEED:      cfg_q.base_speed           <= cfg_data[7:0];
				REG_TURN_SPEED:      cfg_q.turn_speed           <= cfg_data[7:0];
				REG_CURVE_ADJUST:    cfg_q.curve_adjust         <= cfg_data[7:0];
				REG_LINE_LOST_MS:    cfg_q.line_lost_timeout_ms <= cfg_data;
				REG_DEAD_CONFIRM_MS: cfg_q.dead_end_confirm_ms  <= cfg_data;
				REG_CROSS_PASS_MS:   cfg_q.intersection_pass_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ===== src/lfc_core.sv =====
// Decision logic and behavior state of the line-follow controller.
// Turns one registered sample into one or two motor commands. Depends on lfc_pkg.
`default_nettype none
module lfc_core #(
	parameter int PWM_MAX   = lfc_pkg::PWM_MAX_DEF,
	parameter int TIME_BITS = lfc_pkg::TIME_BITS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire lfc_pkg::cfg_t cfg,
	input  wire lfc_pkg::in_t  smp,
	input  wire logic  adv,
	output lfc_pkg::out_t res0,
	output lfc_pkg::out_t res1,
	output logic       two
);
	import lfc_pkg::*;

	localparam int NOW_BITS = (TIME_BITS < 32) ? TIME_BITS : 32;
	localparam logic [16:0] PwmMaxWide = 17'(PWM_MAX);
	localparam logic [7:0]  PwmMaxLo   = 8'(PWM_MAX);

	logic [TIME_BITS-1:0] last_seen_q;
	logic                 dead_armed_q;
	logic [TIME_BITS-1:0] dead_start_q;
	logic                 cross_active_q;
	logic [TIME_BITS-1:0] cross_start_q;
	heading_t             heading_q;

	logic                 l_on, m_on, r_on, any_on, all_on, cross_pat;
	logic [TIME_BITS-1:0] now_t, dead_el, cross_el, lost_el;
	logic                 dead_fire, cross_run, bridge_run;
	logic signed [10:0]   base_s, turn_s, adj_s, lraw, rraw;
	action_t              act;
	dir_t                 ldir, rdir;
	logic                 set_head;
	heading_t             head_nxt;

	function automatic logic [7:0] sat_pwm(input logic signed [10:0] v);
		logic [16:0] mag;
		mag = {7'd0, v[9:0]};
		if (v < 0)
			return 8'd0;
		if (mag > PwmMaxWide)
			return PwmMaxLo;
		return v[7:0];
	endfunction

	assign l_on      = smp.left_level > cfg.left_threshold;
	assign m_on      = smp.middle_on;
	assign r_on      = smp.right_level > cfg.right_threshold;
	assign any_on    = l_on | m_on | r_on;
	assign all_on    = l_on & m_on & r_on;
	assign cross_pat = l_on & r_on & ~m_on;

	assign now_t    = TIME_BITS'(smp.now_ms[NOW_BITS-1:0]);
	// An idle timer reads as zero elapsed: it starts on this very sample.
	assign dead_el  = dead_armed_q ? (now_t - dead_start_q) : '0;
	assign cross_el = cross_active_q ? (now_t - cross_start_q) : '0;
	assign lost_el  = now_t - last_seen_q;

	assign dead_fire  = dead_el > TIME_BITS'(cfg.dead_end_confirm_ms);
	assign cross_run  = cross_el < TIME_BITS'(cfg.intersection_pass_ms);
	assign bridge_run = lost_el < TIME_BITS'(cfg.line_lost_timeout_ms);

	assign base_s = $signed({3'b000, cfg.base_speed});
	assign turn_s = $signed({3'b000, cfg.turn_speed});
	assign adj_s  = $signed({3'b000, cfg.curve_adjust});

	always_comb begin
		act      = ACT_FWD;
		ldir     = DIR_FWD;
		rdir     = DIR_FWD;
		lraw     = base_s;
		rraw     = base_s;
		set_head = 1'b0;
		head_nxt = HEAD_CENTRE;
		if (all_on) begin
			// Backup of a firing dead end goes here, the spin in res1.
			if (dead_fire) begin
				act      = ACT_BACKUP;
				ldir     = DIR_REV;
				rdir     = DIR_REV;
				lraw     = BACKUP_PWM;
				rraw     = BACKUP_PWM;
				set_head = 1'b1;
			end else begin
				act  = ACT_CHECK_DEAD;
				lraw = base_s - DEAD_OFS;
				rraw = base_s - DEAD_OFS;
			end
		end else if (cross_pat) begin
			if (cross_run) begin
				act = ACT_CROSS;
			end else begin
				act  = ACT_KEEP;
				ldir = DIR_STOP;
				rdir = DIR_STOP;
				lraw = '0;
				rraw = '0;
			end
		end else if (m_on && !l_on && !r_on) begin
			act      = ACT_FWD;
			set_head = 1'b1;
		end else if (l_on && m_on) begin
			act      = ACT_CURVE_R;
			lraw     = base_s + adj_s;
			rraw     = base_s - adj_s;
			set_head = 1'b1;
			head_nxt = HEAD_MINUS;
		end else if (r_on && m_on) begin
			act      = ACT_CURVE_L;
			lraw     = base_s - adj_s;
			rraw     = base_s + adj_s;
			set_head = 1'b1;
			head_nxt = HEAD_PLUS;
		end else if (l_on) begin
			act      = ACT_SHARP_R;
			lraw     = turn_s + TURN_OFS;
			rraw     = turn_s - TURN_OFS;
			set_head = 1'b1;
			head_nxt = HEAD_MINUS;
		end else if (r_on) begin
			act      = ACT_SHARP_L;
			lraw     = turn_s - TURN_OFS;
			rraw     = turn_s + TURN_OFS;
			set_head = 1'b1;
			head_nxt = HEAD_PLUS;
		end else if (bridge_run) begin
			act = ACT_BRIDGE;
		end else if (heading_q == HEAD_PLUS) begin
			act  = ACT_REC_L;
			ldir = DIR_REV;
			lraw = REC_PWM;
			rraw = REC_PWM;
		end else begin
			act  = ACT_REC_R;
			rdir = DIR_REV;
			lraw = REC_PWM;
			rraw = REC_PWM;
		end
	end

	assign two = all_on & dead_fire;

	assign res0.action      = act;
	assign res0.left_dir    = ldir;
	assign res0.right_dir   = rdir;
	assign res0.left_pwm    = sat_pwm(lraw);
	assign res0.right_pwm   = sat_pwm(rraw);
	assign res0.hold_ms     = two ? HOLD_BACKUP : HOLD_NORMAL;
	assign res0.last_of_run = ~two;

	assign res1.action      = ACT_SPIN180;
	assign res1.left_dir    = DIR_FWD;
	assign res1.right_dir   = DIR_REV;
	assign res1.left_pwm    = sat_pwm(SPIN_PWM);
	assign res1.right_pwm   = sat_pwm(SPIN_PWM);
	assign res1.hold_ms     = HOLD_SPIN;
	assign res1.last_of_run = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_seen_q    <= '0;
			dead_armed_q   <= 1'b0;
			dead_start_q   <= '0;
			cross_active_q <= 1'b0;
			cross_start_q  <= '0;
			heading_q      <= HEAD_CENTRE;
		end else if (adv) begin
			if (any_on)
				last_seen_q <= now_t;
			if (all_on) begin
				if (!dead_armed_q) begin
					dead_armed_q <= 1'b1;
					dead_start_q <= now_t;
				end
				if (dead_fire)
					dead_armed_q <= 1'b0;
			end else begin
				dead_armed_q <= 1'b0;
				if (cross_pat) begin
					if (!cross_active_q) begin
						cross_active_q <= 1'b1;
						cross_start_q  <= now_t;
					end
				end else begin
					cross_active_q <= 1'b0;
				end
			end
			if (set_head)
				heading_q <= head_nxt;
		end
	end

`ifndef SYNTHESIS
	a_fire_needs_arm: assert property (@(posedge clk) disable iff (!arst_n)
		two |-> dead_armed_q)
		else $error("dead end fired without an armed timer");
`endif

endmodule
`default_nettype wire

// ===== src/lfc_outq.sv =====
// Four-entry result buffer of the line-follow controller. Depends on lfc_pkg.
// Takes one or two commands per cycle, delivers one per cycle unless stalled.
`default_nettype none
module lfc_outq (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire logic  push_two,
	input  wire lfc_pkg::out_t wr0,
	input  wire lfc_pkg::out_t wr1,
	output logic       room,
	output logic       out_valid,
	input  wire logic  out_stall,
	output lfc_pkg::out_t out_data
);
	import lfc_pkg::*;

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	out_t             ent_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_nx;
	logic [PTR_W:0]   cnt_q, cnt_add;
	logic             pop;

	assign pop       = out_valid & ~out_stall;
	assign out_valid = cnt_q != '0;
	assign out_data  = ent_q[rd_ptr_q];
	// Room for a worst-case sample of two commands.
	assign room      = cnt_q <= (PTR_W+1)'(DEPTH - 2);
	assign wr_ptr_nx = wr_ptr_q + PTR_W'(1);
	assign cnt_add   = push ? (push_two ? (PTR_W+1)'(2) : (PTR_W+1)'(1)) : '0;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= wr0;
			if (push_two)
				ent_q[wr_ptr_nx] <= wr1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PTR_W'(cnt_add);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			cnt_q <= cnt_q + cnt_add - (pop ? (PTR_W+1)'(1) : '0);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> room)
		else $error("result buffer written without room");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (PTR_W+1)'(DEPTH))
		else $error("result buffer count out of range");
	a_two_adds: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_two && !pop) |=> cnt_q == $past(cnt_q) + (PTR_W+1)'(2))
		else $error("double write did not add two entries");
`endif

endmodule
`default_nettype wire

// ===== src/three_sensor_line_follow_controller.sv =====
// Top level of the three-sensor line-follow controller.
// Depends on lfc_pkg, lfc_cfg, lfc_core and lfc_outq.
`default_nettype none
// One sensor sample per transaction on the input channel; one motor command per
// transaction on the output channel. A new sample is taken every clock cycle
// while in_stall is low; the sample is held in the input register, then the
// decision writes its command into the result buffer, which drives the output. A
// dead-end turnaround sample produces two commands, backup then spin, and
// these leave in that order. The four-entry result buffer sets the
// rate under output stall: a sample moves out of the input register only while
// the buffer holds at most two commands, so input stall rises only when the
// consumer falls behind. The last_of_run bit marks the final command of each
// sample. Configuration registers are written through cfg_we/cfg_index/cfg_data
// and take effect on the next sample; write them while no sample is in flight.
// Reset is asynchronous, active low, and needs no clearing pass.
module three_sensor_line_follow_controller #(
	parameter int PWM_MAX   = lfc_pkg::PWM_MAX_DEF,
	parameter int TIME_BITS = lfc_pkg::TIME_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire lfc_pkg::in_t                  in_data,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output lfc_pkg::out_t                      out_data,
	input  wire logic                          cfg_we,
	input  wire logic [lfc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [lfc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lfc_pkg::*;

	cfg_t cfg;
	in_t  smp_s1;
	logic vld_s1;
	logic room, adv, in_acc, two;
	out_t res0, res1;

	// Configuration registers.
	lfc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Advance the registered sample once the buffer can take both commands.
	assign adv      = vld_s1 & room;
	// Hold off new samples only while the input register is occupied and blocked.
	assign in_stall = vld_s1 & ~room;
	assign in_acc   = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_acc) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	// Sample payload: loaded on accept only, no reset.
	always_ff @(posedge clk) begin
		if (in_acc)
			smp_s1 <= in_data;
	end

	// Decision and behavior state; state moves only when the sample advances.
	lfc_core #(
		.PWM_MAX   (PWM_MAX),
		.TIME_BITS (TIME_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.smp    (smp_s1),
		.adv    (adv),
		.res0   (res0),
		.res1   (res1),
		.two    (two)
	);

	// Result buffer parts the decision from the output consumer.
	lfc_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (adv),
		.push_two  (two),
		.wr0       (res0),
		.wr1       (res1),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

`ifndef SYNTHESIS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (vld_s1 && !adv))
		else $error("input stalled while the sample register could advance");
`endif

endmodule
`default_nettype wire

// ===== test/tb_three_sensor_line_follow_controller.sv =====
// Testbench for three_sensor_line_follow_controller: directed and random sensor samples
// checked against a behavioral predictor of the motor command decision.
// Depends on lfc_pkg and the controller RTL.
`timescale 1ns / 100ps

module tb_three_sensor_line_follow_controller;
	import lfc_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_stall;
	in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_t out_data;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	three_sensor_line_follow_controller u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Mirror of the register file, kept in step with every write
	cfg_t settings = '{10'd300, 10'd300, 8'd180, 8'd140, 8'd40, 16'd600, 16'd150, 16'd300};

	// Controller state as the predictor sees it
	logic [31:0] line_seen_ms = '0;
	bit dead_armed = 1'b0;
	logic [31:0] dead_start_ms = '0;
	bit crossing_on = 1'b0;
	logic [31:0] crossing_start_ms = '0;
	heading_t heading = HEAD_CENTRE;

	in_t pending_samples[$];
	out_t expected_cmds[$];
	logic [31:0] stim_time = 32'h0000_1000;

	int samples_taken = 0;
	int cmds_checked = 0;
	int turnarounds = 0;
	int settings_used = 1;
	int mismatches = 0;

	// Sender pacing
	int burst_left = 0;
	int gap_left = 0;

	// Receiver pacing
	int pattern_left = 0;
	int stall_pct = 0;
	int hold_left = 0;
	bit squeeze_done = 1'b0;

	function automatic logic [7:0] clip_pwm(int v);
		if (v < 0)
			return 8'd0;
		if (v > PWM_MAX_DEF)
			return 8'(PWM_MAX_DEF);
		return 8'(v);
	endfunction

	task automatic push_cmd(action_t act, dir_t ld, dir_t rd, int lp, int rp,
			logic [9:0] hold, logic last);
		out_t c;
		c.action = act;
		c.left_dir = ld;
		c.right_dir = rd;
		c.left_pwm = clip_pwm(lp);
		c.right_pwm = clip_pwm(rp);
		c.hold_ms = hold;
		c.last_of_run = last;
		expected_cmds.push_back(c);
	endtask

	// Work out the command(s) one accepted sample causes and advance the state.
	task automatic predict_sample(in_t s);
		bit l_on, m_on, r_on;
		int base, turn, adj;
		logic [31:0] elapsed;
		l_on = s.left_level > settings.left_threshold;
		m_on = s.middle_on;
		r_on = s.right_level > settings.right_threshold;
		base = settings.base_speed;
		turn = settings.turn_speed;
		adj = settings.curve_adjust;

		if (l_on || m_on || r_on)
			line_seen_ms = s.now_ms;

		// All black: confirm the dead end, then back up and turn around.
		// Crossing state is left alone here on purpose.
		if (l_on && m_on && r_on) begin
			if (!dead_armed) begin
				dead_armed = 1'b1;
				dead_start_ms = s.now_ms;
			end
			elapsed = s.now_ms - dead_start_ms;
			if (elapsed > settings.dead_end_confirm_ms) begin
				push_cmd(ACT_BACKUP, DIR_REV, DIR_REV, int'(BACKUP_PWM), int'(BACKUP_PWM),
					HOLD_BACKUP, 1'b0);
				push_cmd(ACT_SPIN180, DIR_FWD, DIR_REV, int'(SPIN_PWM), int'(SPIN_PWM),
					HOLD_SPIN, 1'b1);
				dead_armed = 1'b0;
				heading = HEAD_CENTRE;
				turnarounds++;
			end else begin
				push_cmd(ACT_CHECK_DEAD, DIR_FWD, DIR_FWD, base - int'(DEAD_OFS),
					base - int'(DEAD_OFS), HOLD_NORMAL, 1'b1);
			end
			return;
		end
		dead_armed = 1'b0;

		// Both outer sensors without the middle: timed pass, then keep
		if (l_on && r_on) begin
			if (!crossing_on) begin
				crossing_on = 1'b1;
				crossing_start_ms = s.now_ms;
			end
			elapsed = s.now_ms - crossing_start_ms;
			if (elapsed < settings.intersection_pass_ms)
				push_cmd(ACT_CROSS, DIR_FWD, DIR_FWD, base, base, HOLD_NORMAL, 1'b1);
			else
				push_cmd(ACT_KEEP, DIR_STOP, DIR_STOP, 0, 0, HOLD_NORMAL, 1'b1);
			return;
		end
		crossing_on = 1'b0;

		elapsed = s.now_ms - line_seen_ms;
		if (m_on && !l_on && !r_on) begin
			push_cmd(ACT_FWD, DIR_FWD, DIR_FWD, base, base, HOLD_NORMAL, 1'b1);
			heading = HEAD_CENTRE;
		end else if (l_on && m_on) begin
			push_cmd(ACT_CURVE_R, DIR_FWD, DIR_FWD, base + adj, base - adj, HOLD_NORMAL, 1'b1);
			heading = HEAD_MINUS;
		end else if (r_on && m_on) begin
			push_cmd(ACT_CURVE_L, DIR_FWD, DIR_FWD, base - adj, base + adj, HOLD_NORMAL, 1'b1);
			heading = HEAD_PLUS;
		end else if (l_on) begin
			push_cmd(ACT_SHARP_R, DIR_FWD, DIR_FWD, turn + int'(TURN_OFS),
				turn - int'(TURN_OFS), HOLD_NORMAL, 1'b1);
			heading = HEAD_MINUS;
		end else if (r_on) begin
			push_cmd(ACT_SHARP_L, DIR_FWD, DIR_FWD, turn - int'(TURN_OFS),
				turn + int'(TURN_OFS), HOLD_NORMAL, 1'b1);
			heading = HEAD_PLUS;
		end else if (elapsed < settings.line_lost_timeout_ms) begin
			push_cmd(ACT_BRIDGE, DIR_FWD, DIR_FWD, base, base, HOLD_NORMAL, 1'b1);
		end else if (heading == HEAD_PLUS) begin
			push_cmd(ACT_REC_L, DIR_REV, DIR_FWD, int'(REC_PWM), int'(REC_PWM),
				HOLD_NORMAL, 1'b1);
		end else begin
			push_cmd(ACT_REC_R, DIR_FWD, DIR_REV, int'(REC_PWM), int'(REC_PWM),
				HOLD_NORMAL, 1'b1);
		end
	endtask

	function automatic string fmt_cmd(out_t c);
		return $sformatf("act=%0d ldir=%0d rdir=%0d lpwm=%0d rpwm=%0d hold=%0d last=%0d",
			c.action, c.left_dir, c.right_dir, c.left_pwm, c.right_pwm, c.hold_ms,
			c.last_of_run);
	endfunction

	// Sender: take samples from the pending queue in bursts with random gaps.
	// Hold the payload while stalled; predict on each accepted transaction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_sample(in_data);
				samples_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_samples.size() > 0) begin
					in_data <= pending_samples.pop_front();
					in_valid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						// New burst; a third of them run straight into the next one
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: check each accepted command against the oldest expectation,
	// then choose the next stall from a rate picked anew after each random-length pattern.
	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_cmds.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: command with nothing expected: %s", $realtime,
							fmt_cmd(out_data));
					mismatches++;
				end else begin
					want = expected_cmds.pop_front();
					if (out_data.action !== want.action || out_data.left_dir !== want.left_dir ||
							out_data.right_dir !== want.right_dir ||
							out_data.left_pwm !== want.left_pwm ||
							out_data.right_pwm !== want.right_pwm ||
							out_data.hold_ms !== want.hold_ms ||
							out_data.last_of_run !== want.last_of_run) begin
						if (mismatches < 10)
							$display("%0t: command mismatch\n  expected %s\n  actual   %s",
								$realtime, fmt_cmd(want), fmt_cmd(out_data));
						mismatches++;
					end
				end
				cmds_checked++;
			end

			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (cmds_checked >= 250 && !squeeze_done &&
					pending_samples.size() >= 40) begin
				// Long hold-off once mid-run: let the result buffer fill and back up the input
				squeeze_done = 1'b1;
				hold_left = 150;
				out_stall <= 1'b1;
			end else if ($urandom_range(0, 999) == 0) begin
				hold_left = $urandom_range(20, 60);
				out_stall <= 1'b1;
			end else begin
				if (pattern_left == 0) begin
					pattern_left = $urandom_range(16, 96);
					case ($urandom_range(0, 3))
						0: stall_pct = 0;
						1: stall_pct = 20;
						2: stall_pct = 50;
						default: stall_pct = 85;
					endcase
				end
				pattern_left--;
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	task automatic write_reg(reg_idx_t r, logic [15:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		case (r)
			REG_LEFT_THRESHOLD:  settings.left_threshold = v[9:0];
			REG_RIGHT_THRESHOLD: settings.right_threshold = v[9:0];
			REG_BASE_SPEED:      settings.base_speed = v[7:0];
			REG_TURN_SPEED:      settings.turn_speed = v[7:0];
			REG_CURVE_ADJUST:    settings.curve_adjust = v[7:0];
			REG_LINE_LOST_MS:    settings.line_lost_timeout_ms = v;
			REG_DEAD_CONFIRM_MS: settings.dead_end_confirm_ms = v;
			REG_CROSS_PASS_MS:   settings.intersection_pass_ms = v;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_settings(int lt, int rt, int bs, int ts, int ca, int lost, int dead,
			int pass);
		write_reg(REG_LEFT_THRESHOLD, 16'(lt));
		write_reg(REG_RIGHT_THRESHOLD, 16'(rt));
		write_reg(REG_BASE_SPEED, 16'(bs));
		write_reg(REG_TURN_SPEED, 16'(ts));
		write_reg(REG_CURVE_ADJUST, 16'(ca));
		write_reg(REG_LINE_LOST_MS, 16'(lost));
		write_reg(REG_DEAD_CONFIRM_MS, 16'(dead));
		write_reg(REG_CROSS_PASS_MS, 16'(pass));
		settings_used++;
		@(negedge clk);
	endtask

	task automatic add_sample(int l, bit m, int r, logic [31:0] t);
		in_t s;
		s.left_level = 10'(l);
		s.middle_on = m;
		s.right_level = 10'(r);
		s.now_ms = t;
		pending_samples.push_back(s);
	endtask

	// Pick a level on the wanted side of the threshold, often right next to it.
	// A threshold of 1023 cannot be exceeded, so the level falls at or below it then.
	function automatic logic [9:0] pick_level(bit on, logic [9:0] thr);
		int lo, hi;
		if (on && thr != 10'h3FF) begin
			lo = int'(thr) + 1;
			hi = 1023;
			if ($urandom_range(0, 3) == 0)
				hi = (lo + 2 > 1023) ? 1023 : lo + 2;
		end else begin
			lo = 0;
			hi = thr;
			if ($urandom_range(0, 3) == 0)
				lo = (hi < 2) ? 0 : hi - 2;
		end
		return 10'($urandom_range(lo, hi));
	endfunction

	// Time between samples: mostly short, sometimes around the timeouts, rarely huge
	function automatic logic [31:0] pick_step();
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1, 2, 3, 4, 5: return $urandom_range(1, 60);
			6, 7: return $urandom_range(60, 400);
			8: return $urandom_range(400, 1200);
			default: return $urandom_range(1000, 70000);
		endcase
	endfunction

	function automatic int pick_timeout();
		return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 800);
	endfunction

	// Queue runs of samples that keep one sensor pattern, so the timed behaviors
	// (dead-end confirm, crossing pass, line-lost bridging) play out; mix in
	// pattern changes and pure noise.
	task automatic queue_runs(int count);
		int kind, run_len, pat, k;
		bit [2:0] lmr;
		in_t s;
		while (count > 0) begin
			kind = $urandom_range(0, 9);
			run_len = $urandom_range(2, 10);
			for (k = 0; k < run_len && count > 0; k++) begin
				if (kind == 9) begin
					s.left_level = 10'($urandom);
					s.middle_on = 1'($urandom);
					s.right_level = 10'($urandom);
					stim_time += ($urandom_range(0, 3) == 0) ? $urandom : pick_step();
				end else begin
					pat = (kind == 8) ? $urandom_range(0, 7) : kind;
					case (pat)
						0: lmr = 3'b111;   // dead end
						1: lmr = 3'b101;   // crossing
						2: lmr = 3'b010;   // centred
						3: lmr = 3'b110;
						4: lmr = 3'b011;
						5: lmr = 3'b100;
						6: lmr = 3'b001;
						default: lmr = 3'b000;  // line lost
					endcase
					s.left_level = pick_level(lmr[2], settings.left_threshold);
					s.middle_on = lmr[1];
					s.right_level = pick_level(lmr[0], settings.right_threshold);
					stim_time += pick_step();
				end
				s.now_ms = stim_time;
				pending_samples.push_back(s);
				count--;
			end
		end
	endtask

	// Wait until every queued sample went in and every command came out,
	// then go on waiting for anything still inside the pipeline.
	task automatic drain();
		while (pending_samples.size() != 0 || in_valid || expected_cmds.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		int phase;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part at reset settings: every command, threshold edges,
		// timeouts on both sides, recovery both ways and time wrap
		add_sample(0, 1'b1, 0, 32'h1000);            // forward
		add_sample(1023, 1'b1, 0, 32'h1005);         // curve right
		add_sample(0, 1'b1, 1023, 32'h100A);         // curve left
		add_sample(301, 1'b0, 0, 32'h100F);          // sharp right, heading minus
		add_sample(300, 1'b0, 300, 32'h1014);        // at threshold is off: bridge
		add_sample(0, 1'b0, 0, 32'h1014 + 600);      // lost timeout reached: recover right
		add_sample(0, 1'b0, 301, 32'h1300);          // sharp left, heading plus
		add_sample(0, 1'b0, 0, 32'h1600);            // recover left
		add_sample(1023, 1'b0, 1023, 32'h2000);      // crossing starts
		add_sample(512, 1'b0, 700, 32'h2000 + 299);  // still passing
		add_sample(301, 1'b0, 301, 32'h2000 + 300);  // pass time over: keep
		add_sample(1023, 1'b0, 1023, 32'h2200);      // keep while crossing stays
		add_sample(1023, 1'b1, 1023, 32'h3000);      // dead end armed
		add_sample(1023, 1'b1, 1023, 32'h3000 + 150); // confirm time not exceeded
		add_sample(1023, 1'b1, 1023, 32'h3000 + 151); // backup then spin
		add_sample(1023, 1'b1, 1023, 32'h3000 + 152); // re-armed
		add_sample(0, 1'b0, 0, 32'h3400);            // heading centre: recover right
		add_sample(0, 1'b1, 0, 32'hFFFF_FFF0);       // forward just before wrap
		add_sample(0, 1'b0, 0, 32'h0000_0010);       // bridge across wrap
		add_sample(1023, 1'b1, 1023, 32'hFFFF_FFFF);
		add_sample(0, 1'b0, 0, 32'h0000_0000);
		add_sample(1023, 1'b1, 1023, 32'hFFFF_FF80); // dead end timed across wrap
		add_sample(1023, 1'b1, 1023, 32'h0000_0020);
		drain();

		stim_time = 32'hFFFF_F000;
		queue_runs(110);
		drain();

		// Extremes: any level above zero counts as line, sums overflow, zero timeouts
		apply_settings(0, 0, 255, 255, 255, 0, 0, 0);
		stim_time = $urandom;
		queue_runs(110);
		drain();

		// Extremes the other way: outer sensors blind, zero speeds, longest timeouts
		apply_settings(1023, 1023, 0, 0, 0, 65535, 65535, 65535);
		queue_runs(60);
		drain();

		for (phase = 0; phase < 4; phase++) begin
			apply_settings($urandom_range(0, 1023), $urandom_range(0, 1023),
				$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
				pick_timeout(), pick_timeout(), pick_timeout());
			stim_time = $urandom;
			queue_runs(110);
			drain();
		end

		repeat (8) @(negedge clk);
		$display("run covered %0d samples and %0d commands over %0d register settings,",
			samples_taken, cmds_checked, settings_used);
		$display("including %0d dead-end turnarounds; %0d mismatches", turnarounds, mismatches);
		if (mismatches == 0 && expected_cmds.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run
	initial begin
		#10_000_000;
		$display("timeout with %0d commands still expected", expected_cmds.size());
		$display("tb: failure");
		$finish;
	end

endmodule
